>>> design/obd_pkg.sv
`default_nettype none
package obd_pkg;

    localparam int SIGNAL_SLOTS_DEF  = 96;
    localparam int COMMAND_CHARS_DEF = 31;

    localparam logic [1:0] REQ_CMD  = 2'd0;
    localparam logic [1:0] REQ_SIG  = 2'd1;
    localparam logic [1:0] REQ_STAT = 2'd2;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_PROMPT = 8'h3E;

    // text replies, left aligned in 18 characters
    localparam logic [143:0] TXT_BANNER = "OBD RESPONDER v1.5";
    localparam logic [143:0] TXT_OK     = {"OK", 128'h0};
    localparam logic [143:0] TXT_QUERY  = {"?", 136'h0};
    localparam logic [143:0] TXT_NODATA = {"NO DATA", 88'h0};

    typedef enum logic [2:0] {
        RK_HEX,
        RK_BANNER,
        RK_OK,
        RK_QUERY,
        RK_NODATA
    } reply_kind_t;

    typedef enum logic [2:0] {
        SC_NONE,
        SC_255,
        SC_40,
        SC_1,
        SC_4,
        SC_1000
    } scale_t;

    typedef struct packed {
        logic take;
        logic rd;
        logic mul;
        logic div;
        logic scl;
        logic load;
        logic adv;
    } ctl_cmd_t;

    typedef struct packed {
        logic answer;
        logic last_char;
        logic out_free;
    } dp_stat_t;

    function automatic logic [7:0] hex_char(logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h37 + {4'h0, n};
    endfunction

    // {invalid, value}
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [7:0] d;
        d = 8'h0;
        if (c >= "0" && c <= "9") begin
            d = c - 8'h30;
            return {1'b0, d[3:0]};
        end
        if (c >= "A" && c <= "F") begin
            d = c - 8'h37;
            return {1'b0, d[3:0]};
        end
        if (c >= "a" && c <= "f") begin
            d = c - 8'h57;
            return {1'b0, d[3:0]};
        end
        return 5'b10000;
    endfunction

    function automatic logic [7:0] text_char(reply_kind_t k, logic [4:0] i);
        logic [143:0] s;
        int j;
        case (k)
            RK_BANNER: s = TXT_BANNER;
            RK_OK:     s = TXT_OK;
            RK_QUERY:  s = TXT_QUERY;
            default:   s = TXT_NODATA;
        endcase
        j = 143 - 8 * int'(i);
        if (i > 5'd17) return 8'h0;
        return s[j -: 8];
    endfunction

endpackage
`default_nettype wire

>>> design/obd_if.sv
`default_nettype none
interface obd_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [7:0]         cmd_char;
    logic               cmd_last;
    logic [15:0]        signal_index;
    logic signed [31:0] signal_value;
    logic               lamp_on;
    logic [7:0]         fault_count;

    modport source (output valid, req_type, cmd_char, cmd_last, signal_index,
                    signal_value, lamp_on, fault_count, input ready);
    modport sink (input valid, req_type, cmd_char, cmd_last, signal_index,
                  signal_value, lamp_on, fault_count, output ready);
endinterface

interface obd_resp_if;
    logic       valid;
    logic       ready;
    logic [7:0] resp_char;
    logic       resp_last;

    modport source (output valid, resp_char, resp_last, input ready);
    modport sink (input valid, resp_char, resp_last, output ready);
endinterface
`default_nettype wire

>>> design/obd_dp.sv
`default_nettype none
module obd_dp #(
    parameter int SIGNAL_SLOTS  = 96,
    parameter int COMMAND_CHARS = 31
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         req_type,
    input  logic [7:0]         cmd_char,
    input  logic               cmd_last,
    input  logic [15:0]        signal_index,
    input  logic signed [31:0] signal_value,
    input  logic               lamp_on,
    input  logic [7:0]         fault_count,
    input  obd_pkg::ctl_cmd_t  cmd,
    output obd_pkg::dp_stat_t  stat,
    input  logic               resp_ready,
    output logic               resp_valid,
    output logic [7:0]         resp_char,
    output logic               resp_last
);
    import obd_pkg::*;

    localparam int IDXW = $clog2(SIGNAL_SLOTS);
    localparam int LENW = $clog2(COMMAND_CHARS + 1);

    logic [LENW-1:0] len_reg, len_next;
    logic [7:0]      c_reg [4];
    logic [7:0]      ch_up;
    logic            keep;
    logic            lamp_reg;
    logic [7:0]      count_reg;
    logic [SIGNAL_SLOTS-1:0] pres_reg;
    logic            sig_wr;
    logic [31:0]     store_mem [SIGNAL_SLOTS];
    logic [31:0]     sig_q;

    logic [4:0]      hv, lv;
    logic [7:0]      pid;
    logic            pid_ok;
    scale_t          scale;
    logic [31:0]     mask;

    logic signed [10:0] fac;
    logic signed [42:0] prod;
    logic signed [42:0] num_reg;
    logic [42:0]        sh;
    logic [16:0]        t_reg;
    logic [14:0]        x;
    logic [30:0]        prod2;
    logic [15:0]        a_reg, a_next;

    reply_kind_t     kind_reg, kind_next;
    logic [4:0]      blen_reg, blen_next;
    logic [47:0]     hbuf_reg, hbuf_next;
    logic [4:0]      pos_reg;
    logic            in_body;
    logic [4:0]      trail;
    logic [7:0]      cur_char;
    logic            cur_last;
    logic            rv_reg;
    logic [7:0]      rchar_reg;
    logic            rlast_reg;

    // command capture; only the first four characters are ever decoded
    assign ch_up = (cmd_char >= "a" && cmd_char <= "z") ? cmd_char - 8'd32 : cmd_char;
    assign keep  = cmd_char != CH_CR && cmd_char != CH_LF && cmd_char != CH_SP
                   && len_reg < LENW'(COMMAND_CHARS);
    assign len_next = keep ? len_reg + 1'b1 : len_reg;
    assign stat.answer = req_type == REQ_CMD && cmd_last && len_next != '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            lamp_reg  <= 1'b0;
            count_reg <= 8'h0;
            pres_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
                len_reg <= '0;
            else if (cmd.take && req_type == REQ_CMD)
                len_reg <= len_next;
            if (cmd.take && req_type == REQ_STAT)
            begin
                lamp_reg  <= lamp_on;
                count_reg <= fault_count;
            end
            if (sig_wr)
                pres_reg[signal_index[IDXW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && req_type == REQ_CMD && keep && len_reg < LENW'(4))
            c_reg[len_reg[1:0]] <= ch_up;
    end

    assign sig_wr = cmd.take && req_type == REQ_SIG && signal_index < 16'(SIGNAL_SLOTS);

    always_ff @(posedge clk)
    begin
        if (sig_wr)
            store_mem[signal_index[IDXW-1:0]] <= signal_value;
        if (cmd.rd)
            sig_q <= store_mem[pid[IDXW-1:0]];
    end

    // PID decode
    always_comb
    begin
        hv = hex_val(c_reg[2]);
        lv = hex_val(c_reg[3]);
        pid = lv[4] ? {4'h0, hv[3:0]} : {hv[3:0], lv[3:0]};
        pid_ok = ({1'b0, pid} < 9'(SIGNAL_SLOTS)) && pres_reg[pid[IDXW-1:0]];
        case (pid)
            8'h04, 8'h11, 8'h2F: scale = SC_255;
            8'h05, 8'h0F:        scale = SC_40;
            8'h0B, 8'h0D:        scale = SC_1;
            8'h0C:               scale = SC_4;
            8'h42:               scale = SC_1000;
            default:             scale = SC_NONE;
        endcase
        mask = 32'h0;
        mask[31] = 1'b1;
        for (int p = 2; p <= 32; p++)
            mask[32-p] = pres_reg[p];
    end

    // scaling pipeline: multiply, take integer part, divide by 100 where needed
    always_comb
    begin
        case (scale)
            SC_255:  fac = 11'sd255;
            SC_4:    fac = 11'sd4;
            SC_1000: fac = 11'sd1000;
            default: fac = 11'sd1;
        endcase
        prod = $signed(sig_q) * fac;
        if (scale == SC_40)
            prod = prod + 43'sd2621440;
        sh = num_reg >>> 16;
        x = (t_reg >= 17'd25600) ? 15'd25600 : t_reg[14:0];
        prod2 = x * 16'd41944;
        case (scale)
            SC_255:  a_next = (prod2[30:22] > 9'd255) ? 16'd255 : {7'h0, prod2[30:22]};
            SC_4, SC_1000: a_next = t_reg[16] ? 16'hFFFF : t_reg[15:0];
            default: a_next = (t_reg > 17'd255) ? 16'd255 : {8'h0, t_reg[7:0]};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            num_reg <= prod;
        if (cmd.div)
        begin
            if (num_reg <= 43'sd0)
                t_reg <= 17'h0;
            else if (sh[42:16] != 27'h0)
                t_reg <= 17'h10000;
            else
                t_reg <= sh[16:0];
        end
        if (cmd.scl)
            a_reg <= a_next;
    end

    // reply selection
    always_comb
    begin
        kind_next = RK_NODATA;
        blen_next = 5'd7;
        hbuf_next = 48'h0;
        if (len_reg >= LENW'(2) && c_reg[0] == "A" && c_reg[1] == "T")
        begin
            if (len_reg == LENW'(3) && (c_reg[2] == "Z" || c_reg[2] == "I"))
            begin
                kind_next = RK_BANNER;
                blen_next = 5'd18;
            end
            else
            begin
                kind_next = RK_OK;
                blen_next = 5'd2;
            end
        end
        else if (len_reg == LENW'(2) && c_reg[0] == "0" && c_reg[1] == "3")
        begin
            kind_next = RK_HEX;
            if (lamp_reg && count_reg != 8'h0)
            begin
                hbuf_next = {8'h43, 8'h01, 8'hFF, 8'hFF, 16'h0};
                blen_next = 5'd8;
            end
            else
            begin
                hbuf_next = {8'h43, 8'h00, 32'h0};
                blen_next = 5'd4;
            end
        end
        else if (len_reg == LENW'(2) && c_reg[0] == "0" && c_reg[1] == "4")
        begin
            kind_next = RK_HEX;
            hbuf_next = {8'h44, 40'h0};
            blen_next = 5'd2;
        end
        else if (len_reg == LENW'(4) && c_reg[0] == "0" && c_reg[1] == "1")
        begin
            if (hv[4])
            begin
                kind_next = RK_QUERY;
                blen_next = 5'd1;
            end
            else if (pid == 8'h00)
            begin
                kind_next = RK_HEX;
                hbuf_next = {8'h41, 8'h00, mask};
                blen_next = 5'd12;
            end
            else if (pid == 8'h01)
            begin
                kind_next = RK_HEX;
                hbuf_next = {8'h41, 8'h01, lamp_reg, count_reg[6:0], 24'h0};
                blen_next = 5'd12;
            end
            else if (pid_ok && scale != SC_NONE)
            begin
                kind_next = RK_HEX;
                if (scale == SC_4 || scale == SC_1000)
                begin
                    hbuf_next = {8'h41, pid, a_reg, 16'h0};
                    blen_next = 5'd8;
                end
                else
                begin
                    hbuf_next = {8'h41, pid, a_reg[7:0], 24'h0};
                    blen_next = 5'd6;
                end
            end
        end
    end

    // character sequencer, body then CR CR '>'
    assign in_body  = pos_reg < blen_reg;
    assign trail    = pos_reg - blen_reg;
    assign cur_last = !in_body && trail == 5'd2;
    always_comb
    begin
        if (in_body)
            cur_char = (kind_reg == RK_HEX) ? hex_char(hbuf_reg[47:44])
                                            : text_char(kind_reg, pos_reg);
        else
            cur_char = (trail == 5'd2) ? CH_PROMPT : CH_CR;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind_next;
            blen_reg <= blen_next;
            hbuf_reg <= hbuf_next;
            pos_reg  <= 5'd0;
        end
        else if (cmd.adv)
        begin
            pos_reg <= pos_reg + 5'd1;
            if (in_body && kind_reg == RK_HEX)
                hbuf_reg <= {hbuf_reg[43:0], 4'h0};
        end
        if (cmd.adv)
        begin
            rchar_reg <= cur_char;
            rlast_reg <= cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else if (cmd.adv)
            rv_reg <= 1'b1;
        else if (resp_ready)
            rv_reg <= 1'b0;
    end

    assign stat.last_char = cur_last;
    assign stat.out_free  = !rv_reg || resp_ready;
    assign resp_valid = rv_reg;
    assign resp_char  = rchar_reg;
    assign resp_last  = rlast_reg;

    a_adv_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.adv |-> (!rv_reg || resp_ready))
        else $error("char loaded over an unread one");
    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> len_reg == '0)
        else $error("command length not cleared after reply");
    a_prompt_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && rlast_reg) |-> rchar_reg == CH_PROMPT)
        else $error("last char is not the prompt");

endmodule
`default_nettype wire

>>> design/obd_ctrl.sv
`default_nettype none
module obd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  obd_pkg::dp_stat_t stat,
    output obd_pkg::ctl_cmd_t cmd
);
    import obd_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_SCL  = 7'b0010000,
        S_LOAD = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        cmd.take = in_valid && in_ready;
        cmd.rd   = state_reg == S_RD;
        cmd.mul  = state_reg == S_MUL;
        cmd.div  = state_reg == S_DIV;
        cmd.scl  = state_reg == S_SCL;
        cmd.load = state_reg == S_LOAD;
        cmd.adv  = state_reg == S_EMIT && stat.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (cmd.take && stat.answer) state_next = S_RD;
            S_RD:   state_next = S_MUL;
            S_MUL:  state_next = S_DIV;
            S_DIV:  state_next = S_SCL;
            S_SCL:  state_next = S_LOAD;
            S_LOAD: state_next = S_EMIT;
            S_EMIT: if (cmd.adv && stat.last_char) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && stat.answer) |=> state_reg == S_RD)
        else $error("answer not started");
    a_load_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_EMIT)
        else $error("emit did not follow load");
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.adv && stat.last_char) |=> in_ready)
        else $error("not idle after last char");

endmodule
`default_nettype wire

>>> design/obd2_text_command_responder_unit.sv
// After the last command byte is accepted, the controller steps through table read,
// multiply, divide, scale and reply load states, then emits the registered reply chars.
// Output: one reply char per cycle while resp.ready does not stall it (4 to 21 chars), set by the sequencer;
// input items are taken one per cycle while idle, none while a reply runs.
// Reset (async, active low): command length, present flags, lamp and count cleared.
`default_nettype none
module obd2_text_command_responder_unit #(
    parameter int SIGNAL_SLOTS  = obd_pkg::SIGNAL_SLOTS_DEF,
    parameter int COMMAND_CHARS = obd_pkg::COMMAND_CHARS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    obd_req_if.sink     req,
    obd_resp_if.source  resp
);
    import obd_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;
    logic     rdy;

    assign req.ready = rdy;

    obd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (rdy),
        .stat     (stat),
        .cmd      (cmd)
    );

    obd_dp #(
        .SIGNAL_SLOTS  (SIGNAL_SLOTS),
        .COMMAND_CHARS (COMMAND_CHARS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_type     (req.req_type),
        .cmd_char     (req.cmd_char),
        .cmd_last     (req.cmd_last),
        .signal_index (req.signal_index),
        .signal_value (req.signal_value),
        .lamp_on      (req.lamp_on),
        .fault_count  (req.fault_count),
        .cmd          (cmd),
        .stat         (stat),
        .resp_ready   (resp.ready),
        .resp_valid   (resp.valid),
        .resp_char    (resp.resp_char),
        .resp_last    (resp.resp_last)
    );

endmodule
`default_nettype wire
